>>> rtl/sbda_pkg.sv
// Shared constants, types and state codes for the signed binary to decimal ASCII converter.
`default_nettype none

package sbda_pkg;

    // Width of the value port, fixed by the word format.
    localparam int VALUE_FIELD_W = 64;
    localparam int CHAR_W        = 8;

    // Default number of value bits that take part in the conversion.
    localparam int DEFAULT_VALUE_WIDTH = 64;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Controller states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // Commands from the controller to the BCD shift register.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic bit_in;
        logic digit_shift;
    } t_bcd_ctrl;

endpackage

`default_nettype wire

>>> rtl/sbda_dabble.sv
// Bit-serial double-dabble BCD shift register with digit-wise left shift for readout.
`default_nettype none

module sbda_dabble #(
    parameter int NUM_DIGITS = 19
) (
    input  wire logic                  i_clk,
    input  wire sbda_pkg::t_bcd_ctrl   i_ctrl,
    output logic [3:0]                 o_top_digit
);
    import sbda_pkg::*;

    localparam int BCD_W = NUM_DIGITS * 4;

    logic [BCD_W-1:0] r_bcd;
    logic [BCD_W-1:0] n_bcd;
    logic [BCD_W-1:0] adjusted;

    // Every digit of five or more gets three added before the shift, so it carries
    // correctly into the next digit when doubled.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                adjusted[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                adjusted[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        if (i_ctrl.clear) begin
            n_bcd = '0;
        end else if (i_ctrl.dabble) begin
            n_bcd = {adjusted[BCD_W-2:0], i_ctrl.bit_in};
        end else if (i_ctrl.digit_shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

>>> rtl/signed_binary_to_decimal_ascii.sv
// Top level: converts one signed integer word into its decimal ASCII characters.
//
//  Channel   Ports                          Handshake
//  input     i_value                        taken when start is high and busy is low
//  output    o_char_code, o_last            one word per cycle with o_valid high
//
// A value goes through bit-serial double dabble over its VALUE_WIDTH bits, then
// leading zeros are dropped, then a step that carries the '-' of a negative number
// and is spent for every number, then the digits are sent. The busy time is the
// same for every value of a given width; the double-dabble loop sets most of it.
// The last character is shown in the cycle after its digit state, in which busy is
// already low, so a new value may be started then; no value is taken while one
// is being converted. Reset is synchronous and active low; the receiver cannot stall.
`default_nettype none

module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sbda_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    start,
    output logic                                         busy,
    input  wire logic signed [sbda_pkg::VALUE_FIELD_W-1:0] i_value,
    output logic                                         o_valid,
    output logic [sbda_pkg::CHAR_W-1:0]                  o_char_code,
    output logic                                         o_last
);
    import sbda_pkg::*;

    // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1).
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_mag, n_mag;
    logic                   r_neg, n_neg;
    logic [BIT_CNT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [LEFT_W-1:0]      r_left, n_left;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   accept;
    logic                   skip_zero;
    logic [3:0]             top_digit;
    t_bcd_ctrl              bcd_ctrl;

    assign raw       = i_value[VALUE_WIDTH-1:0];
    assign accept    = start && (r_state == S_IDLE);
    assign skip_zero = (top_digit == 4'd0) && (r_left > LEFT_W'(1));

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_left      = r_left;
        n_out_valid = 1'b0;
        n_char      = r_char;
        n_last      = 1'b0;
        bcd_ctrl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // The magnitude is kept unsigned, so the most negative value fits.
                    n_neg     = raw[VALUE_WIDTH-1];
                    n_mag     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    n_bit_cnt = BIT_CNT_W'(VALUE_WIDTH - 1);
                    bcd_ctrl.clear = 1'b1;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                bcd_ctrl.dabble = 1'b1;
                bcd_ctrl.bit_in = r_mag[VALUE_WIDTH-1];
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                if (r_bit_cnt == '0) begin
                    n_left  = LEFT_W'(NUM_DIGITS);
                    n_state = S_SKIP;
                end else begin
                    n_bit_cnt = r_bit_cnt - BIT_CNT_W'(1);
                end
            end
            S_SKIP: begin
                if (skip_zero) begin
                    bcd_ctrl.digit_shift = 1'b1;
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    if (r_neg) begin
                        n_out_valid = 1'b1;
                        n_char      = CHAR_MINUS;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_out_valid = 1'b1;
                n_char      = CHAR_ZERO + {4'b0000, top_digit};
                n_last      = (r_left == LEFT_W'(1));
                bcd_ctrl.digit_shift = 1'b1;
                n_left = r_left - LEFT_W'(1);
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_bit_cnt <= n_bit_cnt;
        r_left    <= n_left;
        r_char    <= n_char;
    end

    sbda_dabble #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_ctrl      (bcd_ctrl),
        .o_top_digit (top_digit)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // A character word only follows a cycle spent in the readout states.
    a_valid_from_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_SKIP || r_state == S_EMIT))
        else $error("character word without a readout state");

    // The converter always leaves a proper decimal digit on top during readout.
    a_digit_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (top_digit <= 4'd9))
        else $error("BCD digit out of range during readout");

    // An accepted value starts the conversion in the next cycle.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_CONV))
        else $error("accepted value did not start conversion");

    // The final character ends the run and releases the block.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && !busy && o_char_code != CHAR_MINUS))
        else $error("last character flagged out of place");

endmodule

`default_nettype wire

>>> test/signed_binary_to_decimal_ascii_tb.sv
// Testbench for the signed binary to decimal ASCII converter: random and corner values, checked per character.
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;

    import sbda_pkg::*;

    localparam int VW         = DEFAULT_VALUE_WIDTH;
    localparam int MAX_TEXT   = 20;
    localparam int RANDOM_N   = 450;
    localparam int DRAIN_WAIT = 150;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_decimal_char;

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value;
        logic [6:0]               idle_pct;
        logic                     drain_first;
    } t_pending_word;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic signed [VALUE_FIELD_W-1:0] i_value;
    logic                            o_valid;
    logic [CHAR_W-1:0]               o_char_code;
    logic                            o_last;

    t_pending_word pending_words[$];
    t_decimal_char expected_text[$];
    logic          took;
    int            mismatch_count;

    signed_binary_to_decimal_ascii #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Appends the decimal text of one accepted value, most significant character first.
    task automatic append_decimal_text(input logic [63:0] raw_in);
        logic [63:0]       mask;
        logic [63:0]       sign_bit;
        logic [63:0]       raw;
        logic [63:0]       mag;
        logic              negative;
        logic [CHAR_W-1:0] rev [MAX_TEXT];
        int                count;
        t_decimal_char     ch;
        mask     = {64{1'b1}} >> (64 - VW);
        sign_bit = 64'd1 << (VW - 1);
        raw      = raw_in & mask;
        negative = (raw & sign_bit) != 0;
        mag      = negative ? ((~raw + 64'd1) & mask) : raw;
        count    = 0;
        do begin
            if (count < MAX_TEXT) begin
                rev[count] = CHAR_ZERO + CHAR_W'(mag % 64'd10);
                count++;
            end
            mag = mag / 64'd10;
        end while (mag != 0);
        if (negative && count < MAX_TEXT) begin
            rev[count] = CHAR_MINUS;
            count++;
        end
        for (int k = 0; k < count; k++) begin
            ch.char_code = rev[count - 1 - k];
            ch.last      = (k == count - 1);
            expected_text.push_back(ch);
        end
    endtask

    task automatic add_word(input logic [63:0] value, input int idle_pct, input logic drain);
        t_pending_word w;
        w.value       = value;
        w.idle_pct    = 7'(idle_pct);
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          n;
        int          kind;
        kind = $urandom_range(9);
        if (kind <= 3) begin
            // Random magnitude with up to a chosen number of digits.
            n = $urandom_range(1, 19);
            p = 64'd1;
            for (int k = 0; k < n; k++) p = p * 64'd10;
            v = rand64() % p;
        end else if (kind <= 5) begin
            // Around a power of ten, where the digit count changes.
            n = $urandom_range(0, 18);
            p = 64'd1;
            for (int k = 0; k < n; k++) p = p * 64'd10;
            v = p + 64'($urandom_range(2)) - 64'd1;
        end else if (kind <= 8) begin
            v = rand64();
        end else begin
            v = 64'($urandom_range(20));
        end
        if (kind != 8 && $urandom_range(1)) v = ~v + 64'd1;
        return v;
    endfunction

    // Driver: start and the value change on the falling edge only.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start   <= 1'b0;
            i_value <= '0;
        end else begin
            if (start && took) void'(pending_words.pop_front());
            if (pending_words.size() != 0
                && !(pending_words[0].drain_first && expected_text.size() != 0)
                && $urandom_range(99) >= pending_words[0].idle_pct) begin
                start   <= 1'b1;
                i_value <= pending_words[0].value;
            end else begin
                // The value bus carries junk while start is low.
                start   <= 1'b0;
                i_value <= rand64();
            end
        end
    end

    // Monitor: checks characters first, then records the word taken at this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= start && !busy;
            if (o_valid) begin
                if (expected_text.size() == 0) begin
                    $display("%0t unexpected word: char_code %h last %b",
                             $time, o_char_code, o_last);
                    mismatch_count++;
                end else begin
                    if (o_char_code !== expected_text[0].char_code) begin
                        $display("%0t char_code mismatch: expected %h actual %h",
                                 $time, expected_text[0].char_code, o_char_code);
                        mismatch_count++;
                    end
                    if (o_last !== expected_text[0].last) begin
                        $display("%0t last mismatch: expected %b actual %b",
                                 $time, expected_text[0].last, o_last);
                        mismatch_count++;
                    end
                    void'(expected_text.pop_front());
                end
            end
            if (start && !busy) append_decimal_text(i_value);
        end
    end

    initial begin
        int idle;
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_value        = '0;

        add_word(64'd0, 33, 1'b1);
        add_word(64'd1, 33, 1'b0);
        add_word(-64'sd1, 33, 1'b0);
        add_word(64'd9, 33, 1'b0);
        add_word(64'd10, 33, 1'b0);
        add_word(-64'sd10, 33, 1'b0);
        add_word(64'd99, 33, 1'b0);
        add_word(64'd100, 33, 1'b0);
        add_word(64'd12345, 33, 1'b0);
        add_word(-64'sd12345, 33, 1'b0);
        add_word(64'h7FFF_FFFF_FFFF_FFFF, 33, 1'b0);
        add_word(64'h8000_0000_0000_0000, 33, 1'b0);
        add_word(64'h8000_0000_0000_0001, 33, 1'b0);
        add_word(64'd999999999999999999, 33, 1'b0);
        add_word(-64'sd999999999999999999, 33, 1'b0);
        add_word(64'd1000000000000000000, 33, 1'b0);
        add_word(-64'sd1000000000000000000, 33, 1'b0);
        add_word(64'd9223372036854775800, 33, 1'b0);
        add_word(64'hAAAA_AAAA_AAAA_AAAA, 33, 1'b0);
        add_word(64'h5555_5555_5555_5555, 33, 1'b0);
        add_word(64'h0000_0000_FFFF_FFFF, 33, 1'b0);
        add_word(64'hFFFF_FFFF_0000_0000, 33, 1'b0);

        for (int i = 0; i < RANDOM_N; i++) begin
            idle = (i < RANDOM_N / 3) ? 33 : (i < 2 * RANDOM_N / 3) ? 68 : 0;
            add_word(random_value(), idle, (i % 75) == 0);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_words.size() != 0 || expected_text.size() != 0) @(posedge i_clk);
        // Anything the block still emits now has no expectation and is flagged.
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS signed_binary_to_decimal_ascii");
        end else begin
            $display("FAIL signed_binary_to_decimal_ascii");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("FAIL signed_binary_to_decimal_ascii");
        $finish;
    end

endmodule

>>> sim.f
rtl/sbda_pkg.sv
rtl/sbda_dabble.sv
rtl/signed_binary_to_decimal_ascii.sv
test/signed_binary_to_decimal_ascii_tb.sv
